@@ design/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/ccpi_pkg.sv @@
// Shared constants, codes and controller interface types of the charger controller.
package ccpi_pkg;

  localparam int DUTY_ONE_DEF    = 32768;
  localparam int SAMPLE_BITS_DEF = 16;

  // Charging mode codes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_CC   = 2'd1;
  localparam logic [1:0] MODE_CV   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_VT  = 3'd0;
  localparam logic [2:0] REG_CT  = 3'd1;
  localparam logic [2:0] REG_CUT = 3'd2;
  localparam logic [2:0] REG_CVP = 3'd3;
  localparam logic [2:0] REG_CVI = 3'd4;
  localparam logic [2:0] REG_CCP = 3'd5;
  localparam logic [2:0] REG_CCI = 3'd6;

  // Multiplier operation codes.
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_FF   = 3'd1;
  localparam logic [2:0] OP_VP   = 3'd2;
  localparam logic [2:0] OP_VI   = 3'd3;
  localparam logic [2:0] OP_CP   = 3'd4;
  localparam logic [2:0] OP_CI   = 3'd5;

  typedef struct packed {
    logic       load;
    logic [2:0] mul_op;
    logic [2:0] use_op;
    logic       div_start;
    logic       finish;
  } ccpi_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } ccpi_stat_t;

endpackage

@@ design/ccpi_div.sv @@
// Restoring divider, one quotient bit per cycle.
module ccpi_div #(
  parameter int DVW = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [15:0]    divisor,
  output logic           busy,
  output logic [DVW-1:0] quotient
);
  localparam int CW = $clog2(DVW + 1);

  logic [DVW-1:0] acc;
  logic [15:0]    rem;
  logic [15:0]    dvs;
  logic [CW-1:0]  cnt;
  logic [16:0]    rem_sh;
  logic [16:0]    diff;

  // Trial subtraction of the shifted remainder.
  assign rem_sh = {rem, acc[DVW-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DVW);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= diff[15:0];
        acc <= {acc[DVW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[15:0];
        acc <= {acc[DVW-2:0], 1'b0};
      end
    end
  end
endmodule

@@ design/ccpi_datapath.sv @@
// Datapath: configuration, shared multiplier, loop arithmetic, state and output register.
module ccpi_datapath #(
  parameter int DUTY_ONE    = ccpi_pkg::DUTY_ONE_DEF,
  parameter int SAMPLE_BITS = ccpi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ccpi_pkg::ccpi_cmd_t  cmd,
  output ccpi_pkg::ccpi_stat_t stat,
  input  logic [47:0]          in_data,
  input  logic                 in_en,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_duty,
  output logic [1:0]           out_mode
);
  import ccpi_pkg::*;

  localparam int D1W  = $clog2(DUTY_ONE + 1);
  localparam int DVW  = 16 + D1W;
  localparam int FW   = DVW + 2;
  localparam int SW   = 44;
  localparam logic [15:0] SMASK = (SAMPLE_BITS >= 16) ? 16'hFFFF
                                  : 16'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic signed [SW-1:0] CBND = SW'(64'(DUTY_ONE) << 16);
  localparam logic signed [FW-1:0] DMAX = (DUTY_ONE > 65535) ? FW'(65535) : FW'(DUTY_ONE);
  localparam logic signed [FW-1:0] DONE = FW'(DUTY_ONE);

  // Configuration registers.
  logic [15:0] vt, ct, cut;
  logic [23:0] cvp, cvi, ccp, cci;
  // Sample and loop state.
  logic [15:0] v, i, sup;
  logic        en;
  logic [1:0]  mode_reg, mode_cur;
  logic signed [31:0] vint, cint, vint_new, cint_new;
  logic [15:0] iref;
  logic signed [17:0] cout;
  logic signed [41:0] prod_q;
  logic [DVW-1:0] quo;
  logic div_busy;

  logic signed [16:0] errv, erri, mul_b;
  logic [23:0] mul_a;
  logic signed [SW-1:0] sumv, sumc, clc;
  logic signed [FW-1:0] tot;
  logic [1:0] nxt;
  logic [15:0] duty;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                 input logic signed [41:0] p);
    logic signed [33:0] dl;
    logic signed [34:0] s;
    dl = 34'(p >>> 8);
    s  = 35'(acc) + 35'(dl);
    if (s > 35'sd2147483647) sat_add = 32'sh7FFFFFFF;
    else if (s < -35'sd2147483648) sat_add = 32'sh80000000;
    else sat_add = s[31:0];
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      vt  <= 16'd24000;
      ct  <= 16'd3000;
      cut <= 16'd300;
      cvp <= 24'd65536;
      cvi <= 24'd655;
      ccp <= 24'd2147484;
      cci <= 24'd21475;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VT:  vt  <= cfg_data[15:0];
        REG_CT:  ct  <= cfg_data[15:0];
        REG_CUT: cut <= cfg_data[15:0];
        REG_CVP: cvp <= cfg_data;
        REG_CVI: cvi <= cfg_data;
        REG_CCP: ccp <= cfg_data;
        REG_CCI: cci <= cfg_data;
        default: ;
      endcase
    end
  end

  // Loop errors.
  assign errv = $signed({1'b0, vt}) - $signed({1'b0, v});
  assign erri = $signed({1'b0, iref}) - $signed({1'b0, i});

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      OP_FF: begin mul_a = 24'(DUTY_ONE); mul_b = $signed({1'b0, v}); end
      OP_VP: begin mul_a = cvp; mul_b = errv; end
      OP_VI: begin mul_a = cvi; mul_b = errv; end
      OP_CP: begin mul_a = ccp; mul_b = erri; end
      OP_CI: begin mul_a = cci; mul_b = erri; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_q <= 42'($signed({1'b0, mul_a}) * mul_b);
  end

  // Loop sums and clamps.
  assign sumv = (SW'(vint) <<< 8) + SW'(prod_q);
  assign sumc = (SW'(cint) <<< 8) + SW'(prod_q);
  always_comb begin
    if (sumc > CBND) clc = CBND;
    else if (sumc < -CBND) clc = -CBND;
    else clc = sumc;
  end

  // Sample capture and staged results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v   <= in_data[15:0] & SMASK;
      i   <= in_data[31:16] & SMASK;
      sup <= in_data[47:32] & SMASK;
      en  <= in_en;
      mode_cur <= mode_reg;
    end
    case (cmd.use_op)
      OP_VP: begin
        if (mode_cur != MODE_CV) iref <= ct;
        else if (sumv < 0) iref <= '0;
        else if (sumv > (SW'(ct) <<< 16)) iref <= ct;
        else iref <= sumv[31:16];
      end
      OP_VI: vint_new <= sat_add(vint, prod_q);
      OP_CP: cout <= clc[33:16];
      OP_CI: cint_new <= sat_add(cint, prod_q);
      default: ;
    endcase
  end

  ccpi_div #(.DVW(DVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_q[DVW-1:0]),
    .divisor  (sup),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Next mode.
  always_comb begin
    if (mode_cur == MODE_CC)
      nxt = !en ? MODE_IDLE : ((v >= vt) ? MODE_CV : MODE_CC);
    else if (mode_cur == MODE_CV)
      nxt = (!en || i <= cut) ? MODE_IDLE : ((v < vt) ? MODE_CC : MODE_CV);
    else
      nxt = !en ? MODE_IDLE : ((v < vt) ? MODE_CC : MODE_CV);
  end

  // Duty from loop output plus feedforward.
  assign tot = FW'(cout) + DONE - $signed({2'b0, quo});
  always_comb begin
    if ((mode_cur != MODE_CC && mode_cur != MODE_CV) || sup == 16'd0 || nxt == MODE_IDLE)
      duty = '0;
    else if (tot < 0) duty = '0;
    else if (tot > DMAX) duty = DMAX[15:0];
    else duty = tot[15:0];
  end

  // Mode and integrator update.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= MODE_IDLE;
      vint     <= '0;
      cint     <= '0;
    end else if (cmd.finish) begin
      mode_reg <= nxt;
      if (nxt != MODE_CV) vint <= '0;
      else if (mode_cur == MODE_CV) vint <= vint_new;
      if (nxt == MODE_IDLE) cint <= '0;
      else if (mode_cur == MODE_CC || mode_cur == MODE_CV) cint <= cint_new;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_duty <= duty;
      out_mode <= nxt;
    end
  end

  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid || out_ready;
endmodule

@@ design/ccpi_ctrl.sv @@
// Controller state machine sequencing the multiplier, divider and state update.
module ccpi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ccpi_pkg::ccpi_stat_t stat,
  output ccpi_pkg::ccpi_cmd_t  cmd
);
  import ccpi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FF   = 4'd1;
  localparam logic [3:0] S_VP   = 4'd2;
  localparam logic [3:0] S_VI   = 4'd3;
  localparam logic [3:0] S_CP   = 4'd4;
  localparam logic [3:0] S_CI   = 4'd5;
  localparam logic [3:0] S_CW   = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Each product is used in the state after the one that issues it.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_FF;
        end
      end
      S_FF: begin
        cmd.mul_op = OP_FF;
        state_next = S_VP;
      end
      S_VP: begin
        cmd.mul_op    = OP_VP;
        cmd.div_start = 1'b1;
        state_next    = S_VI;
      end
      S_VI: begin
        cmd.mul_op = OP_VI;
        cmd.use_op = OP_VP;
        state_next = S_CP;
      end
      S_CP: begin
        cmd.mul_op = OP_CP;
        cmd.use_op = OP_VI;
        state_next = S_CI;
      end
      S_CI: begin
        cmd.mul_op = OP_CI;
        cmd.use_op = OP_CP;
        state_next = S_CW;
      end
      S_CW: begin
        cmd.use_op = OP_CI;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!stat.div_busy) state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ design/cccv_charger_pi_controller.sv @@
// Top level of the CC/CV charger controller with cascaded PI loops.
// A request passes states FF, VP, VI, CP, CI, CW, DIV and FIN before its result is valid.
// Requests are taken one at a time, in idle only; DIV waits for the feedforward divider.
// A finished result waits in an output register; the next request is taken meanwhile.
// Reset (synchronous, active high): mode idle, integrators zero, registers to defaults.
module cccv_charger_pi_controller #(
  parameter int DUTY_ONE    = ccpi_pkg::DUTY_ONE_DEF,
  parameter int SAMPLE_BITS = ccpi_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // voltage_sample, current_sample, supply_voltage
  input  logic        s_tuser,   // charge_enable
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // duty
  output logic [1:0]  m_tuser,   // charge_mode
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import ccpi_pkg::*;

  ccpi_cmd_t  cmd;
  ccpi_stat_t stat;

  assign cfg_ready = 1'b1;

  ccpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ccpi_datapath #(.DUTY_ONE(DUTY_ONE), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_tdata),
    .in_en     (s_tuser),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_duty  (m_tdata),
    .out_mode  (m_tuser)
  );
endmodule

@@ design/ccpi_checker.sv @@
// Port-level checker for the charger controller, bound to the top level.
`include "assert_macros.svh"

module ccpi_checker #(
  parameter int DUTY_ONE = ccpi_pkg::DUTY_ONE_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import ccpi_pkg::*;

  // A stalled result stays offered.
  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  // Idle results carry zero duty.
  `ASSERT_IMPL(a_idle_zero, clk, rst, m_tvalid && m_tuser == MODE_IDLE, m_tdata == 16'd0)
  // Duty never exceeds full scale.
  `ASSERT_IMPL(a_duty_max, clk, rst, m_tvalid, 32'(m_tdata) <= 32'(DUTY_ONE))
  // One request at a time: no new request the cycle after one is taken.
  `ASSERT_NEXT(a_one_req, clk, rst, s_tvalid && s_tready, !s_tready)
endmodule

bind cccv_charger_pi_controller ccpi_checker #(.DUTY_ONE(DUTY_ONE)) u_chk (.*);

@@ tb/tb_cccv_charger_pi_controller.sv @@
// Self-checking testbench of the CC/CV charger controller with random samples and settings.
module tb_cccv_charger_pi_controller;
  import ccpi_pkg::*;

  localparam int     DUTY_FULL   = DUTY_ONE_DEF;
  localparam int     WATCH_LIMIT = 20000;
  localparam int     SETTLE      = 100;

  typedef struct packed {
    logic [15:0] duty;
    logic [1:0]  mode;
  } ctl_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  // Predictor copy of registers and state.
  logic [15:0] vt, ct, cut;
  logic [23:0] cvp, cvi, ccp, cci;
  logic [1:0]  pmode;
  longint      vinteg, iinteg;

  ctl_out_t    expected_q[$];
  int          errors = 0;
  int          watch = 0;
  bit          calm = 1'b0;

  cccv_charger_pi_controller dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint floor_div(longint x, int s);
    longint d;
    d = longint'(1) << s;
    if (x >= 0) return x / d;
    return -((-x + d - 1) / d);
  endfunction

  function automatic longint sat(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // Compute duty and mode for one sample and advance the loop state.
  function automatic ctl_out_t predict_duty(logic [15:0] v16, logic [15:0] i16,
                                            logic [15:0] s16, logic en);
    longint v, i, sup, iref, err, sum, cout, ff, duty;
    logic [1:0] nxt;
    ctl_out_t r;
    v = v16; i = i16; sup = s16; duty = 0;
    if (pmode == MODE_CC || pmode == MODE_CV) begin
      iref = ct;
      if (pmode == MODE_CV) begin
        err = longint'(vt) - v;
        sum = vinteg * 256 + longint'(cvp) * err;
        sum = sat(sum, 0, longint'(ct) << 16);
        iref = sum >>> 16;
        vinteg = sat(vinteg + floor_div(longint'(cvi) * err, 8),
                     -64'sd2147483648, 64'sd2147483647);
      end
      err = iref - i;
      sum = iinteg * 256 + longint'(ccp) * err;
      sum = sat(sum, -(longint'(DUTY_FULL) << 16), longint'(DUTY_FULL) << 16);
      cout = floor_div(sum, 16);
      iinteg = sat(iinteg + floor_div(longint'(cci) * err, 8),
                   -64'sd2147483648, 64'sd2147483647);
      if (sup != 0) begin
        ff = DUTY_FULL - (v * DUTY_FULL) / sup;
        duty = sat(cout + ff, 0, DUTY_FULL > 65535 ? 65535 : DUTY_FULL);
      end
      if (pmode == MODE_CC)
        nxt = !en ? MODE_IDLE : (v >= vt ? MODE_CV : MODE_CC);
      else if (!en || i <= cut)
        nxt = MODE_IDLE;
      else
        nxt = v < vt ? MODE_CC : MODE_CV;
    end else begin
      nxt = en ? (v < vt ? MODE_CC : MODE_CV) : MODE_IDLE;
    end
    if (nxt != MODE_CV) vinteg = 0;
    if (nxt == MODE_IDLE) begin
      iinteg = 0;
      duty = 0;
    end
    pmode = nxt;
    r.duty = duty[15:0];
    r.mode = nxt;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic idle_burst();
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 9)) @(posedge clk);
  endtask

  // Send one sample request and record its prediction.
  // The request is raised after the previous one was dropped, sometimes after a random idle gap.
  task automatic send_sample(logic [15:0] v, logic [15:0] i, logic [15:0] s, logic en);
    @(posedge clk);
    idle_burst();
    s_tvalid <= 1'b1;
    s_tdata  <= {s, i, v};
    s_tuser  <= en;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_q.push_back(predict_duty(v, i, s, en));
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_VT:  vt  = val[15:0];
      REG_CT:  ct  = val[15:0];
      REG_CUT: cut = val[15:0];
      REG_CVP: cvp = val;
      REG_CVI: cvi = val;
      REG_CCP: ccp = val;
      REG_CCI: cci = val;
      default: ;
    endcase
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        ctl_out_t e;
        e = expected_q.pop_front();
        if (m_tdata !== e.duty) report_mismatch("duty", m_tdata, e.duty);
        if (m_tuser !== e.mode) report_mismatch("charge_mode", m_tuser, e.mode);
      end
    end
  end

  int stall = 0;
  always @(posedge clk) begin
    if (calm) begin
      m_tready <= 1'b1;
    end else if (stall > 0) begin
      stall <= stall - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall <= $urandom_range(1, 9) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted transfer.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      watch <= 0;
    else
      watch <= watch + 1;
    if (watch >= WATCH_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    send_sample(16'd20000, 16'd1000, 16'd40000, 1'b0);
    send_sample(16'd20000, 16'd1000, 16'd40000, 1'b1);
    send_sample(16'd20000, 16'd1000, 16'd40000, 1'b1);
    send_sample(16'd25000, 16'd2000, 16'd40000, 1'b1);
    send_sample(16'd25000, 16'd2000, 16'd40000, 1'b1);
    send_sample(16'd24000, 16'd2500, 16'd0, 1'b1);
    send_sample(16'd23000, 16'd2500, 16'd40000, 1'b1);
    send_sample(16'd50000, 16'd2500, 16'd30000, 1'b1);
    send_sample(16'd50000, 16'd300, 16'd60000, 1'b1);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 16'hFFFF, 16'd1, 1'b1);
    send_sample(16'd0, 16'd0, 16'hFFFF, 1'b1);
    send_sample(16'd0, 16'hFFFF, 16'd1, 1'b1);
    send_sample(16'd0, 16'd0, 16'd0, 1'b0);
    send_sample(16'd30000, 16'd5000, 16'd40000, 1'b1);
    send_sample(16'd30000, 16'd5000, 16'd40000, 1'b0);
    drain();
  endtask

  // Random samples, mostly clustered around the targets.
  task automatic test_random(int n);
    logic [15:0] v, i, s;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 8) begin
        v = 16'(int'(vt) + $urandom_range(0, 4000) - 2000);
        i = 16'(int'(ct) + $urandom_range(0, 4000) - 2000);
        s = $urandom_range(0, 19) == 0 ? 16'd0 : 16'(int'(vt) + $urandom_range(0, 30000));
      end else begin
        v = 16'($urandom); i = 16'($urandom); s = 16'($urandom);
      end
      send_sample(v, i, s, $urandom_range(0, 15) != 0);
    end
    drain();
  endtask

  task automatic test_settings();
    write_reg(REG_VT, 24'hFFFF);
    write_reg(REG_CT, 24'hFFFF);
    write_reg(REG_CUT, 24'd0);
    write_reg(REG_CVP, 24'hFFFFFF);
    write_reg(REG_CVI, 24'hFFFFFF);
    write_reg(REG_CCP, 24'hFFFFFF);
    write_reg(REG_CCI, 24'hFFFFFF);
    write_reg(3'd7, 24'h123456);
    test_random(60);
    write_reg(REG_VT, 24'd0);
    write_reg(REG_CT, 24'd0);
    write_reg(REG_CUT, 24'hFFFF);
    write_reg(REG_CVP, 24'd0);
    write_reg(REG_CVI, 24'd0);
    write_reg(REG_CCP, 24'd0);
    write_reg(REG_CCI, 24'd0);
    test_random(40);
    for (int r = 0; r < 4; r++) begin
      write_reg(REG_VT, 24'($urandom_range(10000, 40000)));
      write_reg(REG_CT, 24'($urandom_range(500, 8000)));
      write_reg(REG_CUT, 24'($urandom_range(0, 2000)));
      write_reg(REG_CVP, 24'($urandom));
      write_reg(REG_CVI, 24'($urandom_range(0, 100000)));
      write_reg(REG_CCP, 24'($urandom));
      write_reg(REG_CCI, 24'($urandom_range(0, 200000)));
      test_random(50);
    end
  endtask

  initial begin
    vt = 16'd24000; ct = 16'd3000; cut = 16'd300;
    cvp = 24'd65536; cvi = 24'd655; ccp = 24'd2147484; cci = 24'd21475;
    pmode = MODE_IDLE; vinteg = 0; iinteg = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(120);
    test_settings();
    write_reg(REG_VT, 24'd24000);
    write_reg(REG_CT, 24'd3000);
    write_reg(REG_CUT, 24'd300);
    write_reg(REG_CVP, 24'd65536);
    write_reg(REG_CVI, 24'd655);
    write_reg(REG_CCP, 24'd2147484);
    write_reg(REG_CCI, 24'd21475);
    calm = 1'b1;
    test_random(40);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

@@ cccv_charger_pi_controller.f @@
+incdir+design
design/ccpi_pkg.sv
design/ccpi_div.sv
design/ccpi_datapath.sv
design/ccpi_ctrl.sv
design/cccv_charger_pi_controller.sv
design/ccpi_checker.sv
tb/tb_cccv_charger_pi_controller.sv
